>>> hdl/ccp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_pkg
// Shared constants for the control command parser: character codes, result
// codes, name limits and result beat layout.
// ----------------------------------------------------------------------------
package ccp_pkg;

    // fifo name limits
    localparam int NAME_MAX_CHARS = 20;
    localparam int NAME_LEN_W     = 5;
    localparam int NAME_BITS      = 8 * NAME_MAX_CHARS;

    // port field
    localparam int PORT_W = 16;

    // result beat width: 186 bits of fields, padded to whole bytes
    localparam int RES_BITS = 1 + 2 + 2 + PORT_W + NAME_LEN_W + NAME_BITS;
    localparam int RES_W    = ((RES_BITS + 7) / 8) * 8;

    // status codes
    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_ERR = 1'b1;

    // command codes
    localparam logic [1:0] CMD_NONE     = 2'd0;
    localparam logic [1:0] CMD_START    = 2'd1;
    localparam logic [1:0] CMD_STOP     = 2'd2;
    localparam logic [1:0] CMD_STOP_ALL = 2'd3;

    // transport codes
    localparam logic [1:0] TR_NONE = 2'd0;
    localparam logic [1:0] TR_TCP  = 2'd1;
    localparam logic [1:0] TR_UDP  = 2'd2;
    localparam logic [1:0] TR_FIFO = 2'd3;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;

endpackage

>>> hdl/control_command_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// control_command_parser_unit
// Character-serial parser for START/STOP control commands (tcp/udp port,
// fifo name, stop all). One result beat per terminator byte.
// ----------------------------------------------------------------------------
//  channel  dir  width  contents
//  s_axis   in   8      command character; NUL, LF or CR ends a command
//  m_axis   out  192    status, command, transport, port, name length, name
//
//  One character per cycle: each accepted beat makes one state transition
//  between the parser registers, and a terminator loads the result register.
//  s_axis_tready drops only while a result waits and m_axis_tready is low.
//  Synchronous active-low reset returns the parser to expecting 'S' and
//  empties the result register; the name store is not reset.
// ----------------------------------------------------------------------------
module control_command_parser_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [7:0] char_byte
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [0] status, [2:1] command, [4:3] transport, [20:5] port_number,
    // [25:21] name_length, [89:26] name_bytes_low, [153:90] name_bytes_mid,
    // [185:154] name_bytes_high, [191:186] zero
    output logic [ccp_pkg::RES_W-1:0]  m_axis_tdata
);
    import ccp_pkg::*;

    typedef enum logic [5:0] {
        ST_START_S     = 6'd0,
        ST_T           = 6'd1,
        ST_A_OR_O      = 6'd2,
        ST_R           = 6'd3,
        ST_T2          = 6'd4,
        ST_SP_START    = 6'd5,
        ST_SPACES      = 6'd6,
        ST_TCP_C       = 6'd7,
        ST_TCP_P       = 6'd8,
        ST_TCP_SP      = 6'd9,
        ST_UDP_D       = 6'd10,
        ST_UDP_P       = 6'd11,
        ST_UDP_SP      = 6'd12,
        ST_FIFO_I      = 6'd13,
        ST_FIFO_F      = 6'd14,
        ST_FIFO_O      = 6'd15,
        ST_FIFO_SP     = 6'd16,
        ST_STOP_P      = 6'd17,
        ST_STOP_NEXT   = 6'd18,
        ST_STOP_WORD   = 6'd19,
        ST_ALL_L1      = 6'd20,
        ST_ALL_L2      = 6'd21,
        ST_ALL_DONE    = 6'd22,
        ST_PORT_LEAD   = 6'd23,
        ST_P1_LO       = 6'd24,
        ST_P2_LO       = 6'd25,
        ST_P3_LO       = 6'd26,
        ST_P4_LO       = 6'd27,
        ST_P5          = 6'd28,
        ST_P4_END      = 6'd29,
        ST_P3_HI       = 6'd30,
        ST_P4_A        = 6'd31,
        ST_P2_HI       = 6'd32,
        ST_P3_B        = 6'd33,
        ST_P4_B        = 6'd34,
        ST_P1_HI       = 6'd35,
        ST_P2_C        = 6'd36,
        ST_P3_C        = 6'd37,
        ST_P4_C        = 6'd38,
        ST_NAME        = 6'd39,
        ST_DRAIN       = 6'd63
    } t_state;

    t_state                 r_state, n_state;
    logic [PORT_W-1:0]      r_port, n_port;
    logic [1:0]             r_cmd, n_cmd;
    logic [1:0]             r_tr, n_tr;
    logic [NAME_LEN_W-1:0]  r_len, n_len;
    logic [7:0]             r_name [NAME_MAX_CHARS];
    logic                   r_out_valid;
    logic [RES_W-1:0]       r_out_data;

    logic                   in_beat;
    logic [7:0]             ch;
    logic                   is_term;
    logic                   is_digit;
    logic                   is_name_ch;
    logic [3:0]             dig;
    logic [PORT_W-1:0]      port_step;
    logic                   in_port;
    logic                   accepting;
    logic                   name_we;
    logic [NAME_BITS-1:0]   name_vec;
    logic [RES_W-1:0]       n_out_data;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign ch            = s_axis_tdata;
    assign is_term       = (ch == CH_NUL) || (ch == CH_LF) || (ch == CH_CR);
    assign is_digit      = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_name_ch    = ((ch >= CH_A) && (ch <= CH_UC_Z)) ||
                           ((ch >= CH_LC_A) && (ch <= CH_LC_Z)) || (ch == CH_UNDER);
    // low nibble of '0'..'9' is the digit value
    assign dig           = ch[3:0];
    // acc * 10 + d, kept to 16 bits
    assign port_step     = {r_port[PORT_W-4:0], 3'b000} + {r_port[PORT_W-2:0], 1'b0}
                           + {{(PORT_W-4){1'b0}}, dig};
    assign in_port       = (r_state >= ST_PORT_LEAD) && (r_state <= ST_P4_C);
    assign accepting     = (r_state == ST_ALL_DONE) ||
                           ((r_state >= ST_P1_LO) && (r_state <= ST_P4_C)) ||
                           ((r_state == ST_NAME) && (r_len != '0));

    // next parser state for one character
    always_comb begin
        n_state = r_state;
        n_port  = r_port;
        n_cmd   = r_cmd;
        n_tr    = r_tr;
        n_len   = r_len;
        name_we = 1'b0;
        if (is_term) begin
            n_state = ST_START_S;
            n_port  = '0;
            n_cmd   = CMD_NONE;
            n_tr    = TR_NONE;
            n_len   = '0;
        end else if (r_state == ST_DRAIN) begin
            n_state = ST_DRAIN;
        end else if (r_state == ST_NAME) begin
            if (is_name_ch && (r_len < NAME_LEN_W'(NAME_MAX_CHARS))) begin
                name_we = 1'b1;
                n_len   = r_len + 1'b1;
            end else begin
                n_state = ST_DRAIN;
            end
        end else if (in_port && !is_digit) begin
            n_state = ST_DRAIN;
        end else begin
            n_state = ST_DRAIN;
            unique case (r_state)
                ST_START_S:   if (ch == CH_S) n_state = ST_T;
                ST_T:         if (ch == CH_T) n_state = ST_A_OR_O;
                ST_A_OR_O: begin
                    if (ch == CH_A)      n_state = ST_R;
                    else if (ch == CH_O) n_state = ST_STOP_P;
                end
                ST_R:         if (ch == CH_R) n_state = ST_T2;
                ST_T2: begin
                    if (ch == CH_T) begin
                        n_cmd   = CMD_START;
                        n_state = ST_SP_START;
                    end
                end
                ST_SP_START:  if (ch == CH_SPACE) n_state = ST_SPACES;
                ST_SPACES: begin
                    if (ch == CH_SPACE)  n_state = ST_SPACES;
                    else if (ch == CH_T) n_state = ST_TCP_C;
                    else if (ch == CH_U) n_state = ST_UDP_D;
                    else if (ch == CH_F) n_state = ST_FIFO_I;
                end
                ST_TCP_C:     if (ch == CH_C) n_state = ST_TCP_P;
                ST_TCP_P: begin
                    if (ch == CH_P) begin
                        n_tr    = TR_TCP;
                        n_state = ST_TCP_SP;
                    end
                end
                ST_TCP_SP:    if (ch == CH_SPACE) n_state = ST_PORT_LEAD;
                ST_UDP_D:     if (ch == CH_D) n_state = ST_UDP_P;
                ST_UDP_P: begin
                    if (ch == CH_P) begin
                        n_tr    = TR_UDP;
                        n_state = ST_UDP_SP;
                    end
                end
                ST_UDP_SP:    if (ch == CH_SPACE) n_state = ST_PORT_LEAD;
                ST_FIFO_I:    if (ch == CH_I) n_state = ST_FIFO_F;
                ST_FIFO_F:    if (ch == CH_F) n_state = ST_FIFO_O;
                ST_FIFO_O: begin
                    if (ch == CH_O) begin
                        n_tr    = TR_FIFO;
                        n_state = ST_FIFO_SP;
                    end
                end
                ST_FIFO_SP: begin
                    if (ch == CH_SPACE) begin
                        n_state = ST_NAME;
                        n_len   = '0;
                    end
                end
                ST_STOP_P: begin
                    if (ch == CH_P) begin
                        n_cmd   = CMD_STOP;
                        n_state = ST_STOP_NEXT;
                    end
                end
                ST_STOP_NEXT: begin
                    if (ch == CH_SPACE)  n_state = ST_STOP_WORD;
                    else if (ch == CH_A) n_state = ST_ALL_L1;
                end
                ST_STOP_WORD: begin
                    if (ch == CH_T)      n_state = ST_TCP_C;
                    else if (ch == CH_U) n_state = ST_UDP_D;
                    else if (ch == CH_F) n_state = ST_FIFO_I;
                    else if (ch == CH_A) n_state = ST_ALL_L1;
                end
                ST_ALL_L1:    if (ch == CH_L) n_state = ST_ALL_L2;
                ST_ALL_L2: begin
                    if (ch == CH_L) begin
                        n_cmd   = CMD_STOP_ALL;
                        n_state = ST_ALL_DONE;
                    end
                end
                // leading zeros are skipped
                ST_PORT_LEAD: begin
                    if (dig == 4'd0) begin
                        n_state = ST_PORT_LEAD;
                    end else begin
                        n_port  = port_step;
                        n_state = (dig <= 4'd6) ? ST_P1_LO : ST_P1_HI;
                    end
                end
                ST_P1_LO: begin
                    n_port  = port_step;
                    n_state = (dig <= 4'd5) ? ST_P2_LO : ST_P2_HI;
                end
                ST_P2_LO: begin
                    n_port  = port_step;
                    n_state = (dig <= 4'd5) ? ST_P3_LO : ST_P3_HI;
                end
                ST_P3_LO: begin
                    n_port  = port_step;
                    n_state = (dig <= 4'd3) ? ST_P4_LO : ST_P4_END;
                end
                ST_P4_LO: begin
                    if (dig <= 4'd5) begin
                        n_port  = port_step;
                        n_state = ST_P5;
                    end
                end
                ST_P3_HI: begin
                    n_port  = port_step;
                    n_state = ST_P4_A;
                end
                ST_P2_HI: begin
                    n_port  = port_step;
                    n_state = ST_P3_B;
                end
                ST_P3_B: begin
                    n_port  = port_step;
                    n_state = ST_P4_B;
                end
                ST_P1_HI: begin
                    n_port  = port_step;
                    n_state = ST_P2_C;
                end
                ST_P2_C: begin
                    n_port  = port_step;
                    n_state = ST_P3_C;
                end
                ST_P3_C: begin
                    n_port  = port_step;
                    n_state = ST_P4_C;
                end
                // full ports and stop all take no further character
                default:      n_state = ST_DRAIN;
            endcase
        end
    end

    // result beat, name bytes past the length read as zero
    always_comb begin
        for (int i = 0; i < NAME_MAX_CHARS; i++) begin
            name_vec[8*i +: 8] = (NAME_LEN_W'(i) < r_len) ? r_name[i] : 8'h00;
        end
        n_out_data = '0;
        if (accepting) begin
            n_out_data[RES_BITS-1:0] = {name_vec, r_len, r_port, r_tr, r_cmd, STAT_OK};
        end else begin
            n_out_data[0] = STAT_ERR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_START_S;
            r_port      <= '0;
            r_cmd       <= CMD_NONE;
            r_tr        <= TR_NONE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                r_state <= n_state;
                r_port  <= n_port;
                r_cmd   <= n_cmd;
                r_tr    <= n_tr;
                r_len   <= n_len;
            end
            if (in_beat && is_term) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat && is_term) begin
            r_out_data <= n_out_data;
        end
    end

    // name store
    always_ff @(posedge i_clk) begin
        if (in_beat && name_we) begin
            r_name[r_len] <= ch;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_term_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && is_term) |=> m_axis_tvalid)
        else $error("terminator did not produce a result beat");

    a_term_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && is_term) |=> (r_state == ST_START_S && r_port == '0 &&
                                  r_cmd == CMD_NONE && r_tr == TR_NONE))
        else $error("parser not cleared after terminator");

    a_error_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0] == STAT_ERR) |-> (m_axis_tdata[RES_W-1:1] == '0))
        else $error("error beat carries nonzero fields");

    a_name_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= NAME_LEN_W'(NAME_MAX_CHARS))
        else $error("name length beyond store depth");

endmodule

>>> dv/tb_control_command_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_control_command_parser_unit
// Streams command characters into the parser and checks every result beat,
// field by field, against a cycle-free parser model kept in the bench. A
// short directed set of commands comes first, then random commands (mostly
// well formed, some broken, some raw noise) under three stall profiles.
// ----------------------------------------------------------------------------
module tb_control_command_parser_unit;
    import ccp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int CHARS_PER_PHASE = 230;

    // parser states with a special role
    localparam logic [5:0] ST_EXPECT_S   = 6'd0;
    localparam logic [5:0] ST_STOP_ALL   = 6'd22;
    localparam logic [5:0] ST_PORT_LEAD  = 6'd23;
    localparam logic [5:0] ST_PORT_LAST  = 6'd38;
    localparam logic [5:0] ST_NAME_BASE  = 6'd39;
    localparam logic [5:0] ST_DRAIN      = 6'd63;

    // result beat as it sits in m_axis_tdata, lowest field last
    typedef struct packed {
        logic [5:0]        pad;
        logic [31:0]       name_hi;
        logic [63:0]       name_mid;
        logic [63:0]       name_lo;
        logic [4:0]        name_len;
        logic [PORT_W-1:0] port;
        logic [1:0]        transport;
        logic [1:0]        command;
        logic              status;
    } reply_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [RES_W-1:0]   m_axis_tdata;

    control_command_parser_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    logic [7:0] send_chars[$];
    logic [7:0] cmd_buf[$];
    reply_t     expected_replies[$];
    reply_t     next_reply;
    reply_t     oldest_reply;
    reply_t     observed;
    int         send_gap_pct = 0;
    int         recv_stall_pct = 0;
    int         error_count = 0;
    int         cycle_count = 0;

    // model state
    logic [5:0]        pstate = ST_EXPECT_S;
    logic [PORT_W-1:0] port_acc = '0;
    logic [7:0]        name_buf[NAME_MAX_CHARS];
    logic [1:0]        cmd_code = CMD_NONE;
    logic [1:0]        tr_code = TR_NONE;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    function automatic void shift_in_digit(input int d);
        port_acc = PORT_W'(port_acc * 10 + d);
    endfunction

    // One character through the parser model; returns 1 when it ends a command.
    function automatic bit parse_char(input logic [7:0] c, output reply_t r);
        logic [5:0]   nxt;
        logic [159:0] name_bits;
        int           d;
        int           len;
        bit           is_dig;
        bit           is_name;
        r = '0;
        if (c == CH_NUL || c == CH_LF || c == CH_CR) begin
            if (pstate == ST_STOP_ALL
                || (pstate >= 24 && pstate <= ST_PORT_LAST)
                || (pstate > ST_NAME_BASE && pstate <= ST_NAME_BASE + NAME_MAX_CHARS)) begin
                len = (pstate > ST_NAME_BASE) ? int'(pstate - ST_NAME_BASE) : 0;
                name_bits = '0;
                for (int i = 0; i < len; i++) name_bits[8*i +: 8] = name_buf[i];
                r.status    = STAT_OK;
                r.command   = cmd_code;
                r.transport = tr_code;
                r.port      = port_acc;
                r.name_len  = NAME_LEN_W'(len);
                r.name_lo   = name_bits[63:0];
                r.name_mid  = name_bits[127:64];
                r.name_hi   = name_bits[159:128];
            end else begin
                r.status = STAT_ERR;
            end
            pstate   = ST_EXPECT_S;
            port_acc = '0;
            cmd_code = CMD_NONE;
            tr_code  = TR_NONE;
            return 1'b1;
        end
        if (pstate == ST_DRAIN) return 1'b0;
        d       = int'(c) - int'(CH_ZERO);
        is_dig  = (c >= CH_ZERO && c <= CH_NINE);
        is_name = (c >= CH_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z)
                  || c == CH_UNDER;
        nxt = ST_DRAIN;
        if (pstate >= ST_NAME_BASE && pstate < ST_NAME_BASE + NAME_MAX_CHARS) begin
            if (is_name) begin
                name_buf[pstate - ST_NAME_BASE] = c;
                nxt = pstate + 6'd1;
            end
        end else if (pstate >= ST_PORT_LEAD && pstate <= ST_PORT_LAST && !is_dig) begin
            nxt = ST_DRAIN;
        end else begin
            case (pstate)
                6'd0:  if (c == CH_S) nxt = 6'd1;
                6'd1:  if (c == CH_T) nxt = 6'd2;
                6'd2:  if (c == CH_A) nxt = 6'd3; else if (c == CH_O) nxt = 6'd17;
                6'd3:  if (c == CH_R) nxt = 6'd4;
                6'd4:  if (c == CH_T) begin cmd_code = CMD_START; nxt = 6'd5; end
                6'd5:  if (c == CH_SPACE) nxt = 6'd6;
                6'd6: begin
                    if (c == CH_SPACE) nxt = 6'd6;
                    else if (c == CH_T) nxt = 6'd7;
                    else if (c == CH_U) nxt = 6'd10;
                    else if (c == CH_F) nxt = 6'd13;
                end
                6'd7:  if (c == CH_C) nxt = 6'd8;
                6'd8:  if (c == CH_P) begin tr_code = TR_TCP; nxt = 6'd9; end
                6'd9:  if (c == CH_SPACE) nxt = ST_PORT_LEAD;
                6'd10: if (c == CH_D) nxt = 6'd11;
                6'd11: if (c == CH_P) begin tr_code = TR_UDP; nxt = 6'd12; end
                6'd12: if (c == CH_SPACE) nxt = ST_PORT_LEAD;
                6'd13: if (c == CH_I) nxt = 6'd14;
                6'd14: if (c == CH_F) nxt = 6'd15;
                6'd15: if (c == CH_O) begin tr_code = TR_FIFO; nxt = 6'd16; end
                6'd16: if (c == CH_SPACE) nxt = ST_NAME_BASE;
                6'd17: if (c == CH_P) begin cmd_code = CMD_STOP; nxt = 6'd18; end
                6'd18: if (c == CH_SPACE) nxt = 6'd19; else if (c == CH_A) nxt = 6'd20;
                6'd19: begin
                    if (c == CH_T) nxt = 6'd7;
                    else if (c == CH_U) nxt = 6'd10;
                    else if (c == CH_F) nxt = 6'd13;
                    else if (c == CH_A) nxt = 6'd20;
                end
                6'd20: if (c == CH_L) nxt = 6'd21;
                6'd21: if (c == CH_L) begin cmd_code = CMD_STOP_ALL; nxt = ST_STOP_ALL; end
                // leading zeros are skipped; the first significant digit picks the path
                6'd23: begin
                    if (d == 0) nxt = ST_PORT_LEAD;
                    else begin
                        shift_in_digit(d);
                        nxt = (d <= 6) ? 6'd24 : 6'd35;
                    end
                end
                6'd24: begin shift_in_digit(d); nxt = (d <= 5) ? 6'd25 : 6'd32; end
                6'd25: begin shift_in_digit(d); nxt = (d <= 5) ? 6'd26 : 6'd30; end
                6'd26: begin shift_in_digit(d); nxt = (d <= 3) ? 6'd27 : 6'd29; end
                6'd27: if (d <= 5) begin shift_in_digit(d); nxt = 6'd28; end
                6'd30, 6'd32, 6'd33, 6'd35, 6'd36, 6'd37: begin
                    shift_in_digit(d);
                    nxt = pstate + 6'd1;
                end
                default: nxt = ST_DRAIN;
            endcase
        end
        pstate = nxt;
        return 1'b0;
    endfunction

    // ---------------- stimulus building ----------------
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) cmd_buf.push_back(s[i]);
    endtask

    task automatic commit_command();
        foreach (cmd_buf[i]) send_chars.push_back(cmd_buf[i]);
        case ($urandom_range(0, 2))
            0:       send_chars.push_back(CH_NUL);
            1:       send_chars.push_back(CH_LF);
            default: send_chars.push_back(CH_CR);
        endcase
        cmd_buf.delete();
    endtask

    task automatic add_directed(input string s);
        add_text(s);
        commit_command();
    endtask

    task automatic add_port();
        int lead;
        int ndig;
        int d;
        lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (lead) cmd_buf.push_back(CH_ZERO);
        ndig = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 5);
        for (int k = 0; k < ndig; k++) begin
            // lean toward small digits so the five-digit paths get reached
            if (k == 0) d = $urandom_range(1, 9);
            else if ($urandom_range(0, 1)) d = $urandom_range(0, 3);
            else d = $urandom_range(0, 9);
            cmd_buf.push_back(CH_ZERO + 8'(d));
        end
    endtask

    task automatic add_name();
        int len;
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) len = $urandom_range(1, 8);
        else if (r < 95) len = $urandom_range(9, NAME_MAX_CHARS);
        else len = ($urandom_range(0, 1)) ? 0 : NAME_MAX_CHARS + 1;
        repeat (len) begin
            r = $urandom_range(0, 52);
            if (r < 26) cmd_buf.push_back(CH_A + 8'(r));
            else if (r < 52) cmd_buf.push_back(CH_LC_A + 8'(r - 26));
            else cmd_buf.push_back(CH_UNDER);
        end
    endtask

    task automatic add_random_command();
        int kind;
        int pick;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            // raw noise, may hold terminators of its own
            repeat ($urandom_range(1, 12)) cmd_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            pick = $urandom_range(0, 11);
            if (pick == 0) add_text("STOPALL");
            else if (pick == 1) add_text("STOP ALL");
            else begin
                if (pick < 7) begin
                    add_text("START");
                    repeat ($urandom_range(1, 3)) cmd_buf.push_back(CH_SPACE);
                end else begin
                    add_text("STOP ");
                end
                case ($urandom_range(0, 2))
                    0:       begin add_text("TCP "); add_port(); end
                    1:       begin add_text("UDP "); add_port(); end
                    default: begin add_text("FIFO "); add_name(); end
                endcase
            end
            // broken sequences: one byte replaced or the tail cut off
            if (kind >= 85 && cmd_buf.size() > 0) begin
                if ($urandom_range(0, 1))
                    cmd_buf[$urandom_range(0, cmd_buf.size() - 1)] = 8'($urandom_range(0, 255));
                else
                    repeat ($urandom_range(1, cmd_buf.size())) void'(cmd_buf.pop_back());
            end
        end
        commit_command();
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (send_chars.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= send_chars.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ---------------- monitor and checker ----------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (parse_char(s_axis_tdata, next_reply)) expected_replies.push_back(next_reply);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                observed = reply_t'(m_axis_tdata);
                if (expected_replies.size() == 0) begin
                    report_mismatch("beat with no command pending", m_axis_tdata[63:0], '0);
                end else begin
                    oldest_reply = expected_replies.pop_front();
                    if (observed.status !== oldest_reply.status)
                        report_mismatch("status", observed.status, oldest_reply.status);
                    if (observed.command !== oldest_reply.command)
                        report_mismatch("command", observed.command, oldest_reply.command);
                    if (observed.transport !== oldest_reply.transport)
                        report_mismatch("transport", observed.transport, oldest_reply.transport);
                    if (observed.port !== oldest_reply.port)
                        report_mismatch("port_number", observed.port, oldest_reply.port);
                    if (observed.name_len !== oldest_reply.name_len)
                        report_mismatch("name_length", observed.name_len, oldest_reply.name_len);
                    if (observed.name_lo !== oldest_reply.name_lo)
                        report_mismatch("name_bytes_low", observed.name_lo, oldest_reply.name_lo);
                    if (observed.name_mid !== oldest_reply.name_mid)
                        report_mismatch("name_bytes_mid", observed.name_mid, oldest_reply.name_mid);
                    if (observed.name_hi !== oldest_reply.name_hi)
                        report_mismatch("name_bytes_high", observed.name_hi, oldest_reply.name_hi);
                    if (observed.pad !== oldest_reply.pad)
                        report_mismatch("pad bits", observed.pad, oldest_reply.pad);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------- sequence ----------------
    initial begin
        int start_size;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin send_gap_pct = 25; recv_stall_pct = 58; end
                1:       begin send_gap_pct = 58; recv_stall_pct = 25; end
                default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            endcase
            if (phase == 0) begin
                add_directed("");                              // empty command
                add_directed("START TCP 65535");
                add_directed("START   UDP 00080");             // repeated spaces, leading zeros
                add_directed("STOP FIFO a");
                add_directed("STOP FIFO Zz_ABCDEFGHIJKLMNOPQ"); // longest name
                add_directed("START FIFO abcdefghijklmnopqrstu"); // name one too long
                add_directed("START FIFO ");
                add_directed("STOP FIFO a-b");
                add_directed("STOP ALL");
                add_directed("STOPALL");
                add_directed("STOP TCP 65536");                // fifth digit too big
                add_directed("START TCP 000");                 // only zeros
                add_directed("START UDP 99999");
                add_directed("STOP UDP 9999");
                add_directed("START TCP 1234");
                add_directed("START TCP 12345");               // fourth digit ends port
                add_directed("STOP UDP 6599");
                add_directed("STOP UDP 69999");
                add_directed("START UDP 7");
                add_directed("START TCP");                     // incomplete
                add_directed("STOP  TCP 1");                   // double space after STOP
                add_directed("STOPX");
            end
            start_size = send_chars.size();
            while (send_chars.size() - start_size < CHARS_PER_PHASE) add_random_command();
            while (send_chars.size() != 0 || s_axis_tvalid || expected_replies.size() != 0)
                @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/ccp_pkg.sv
hdl/control_command_parser_unit.sv
dv/tb_control_command_parser_unit.sv
